### sv/lifo_stack_with_search_defines.svh
// Assertion macros for the LIFO stack with search.
// Depends on nothing; included by the top level.
`ifndef LIFO_STACK_WITH_SEARCH_DEFINES_SVH
`define LIFO_STACK_WITH_SEARCH_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define LSS_ASSERT_SAME(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("lss assertion failed");
`define LSS_ASSERT_NEXT(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("lss assertion failed");
`else
`define LSS_ASSERT_SAME(lbl, clk, rst, pre, post)
`define LSS_ASSERT_NEXT(lbl, clk, rst, pre, post)
`endif
`endif

### sv/lss_pkg.sv
// Types and constants shared by the LIFO stack controller, datapath and top level.
// Depends on nothing.
package lss_pkg;

  localparam int CW = 6;   // entry count / header count width
  localparam int KW = 3;   // result kind width
  localparam int DW = 32;  // stack entry width

  typedef enum logic [1:0] {
    OP_PUSH,
    OP_POP,
    OP_CLEAR,
    OP_SEARCH
  } op_t;

  localparam logic [KW-1:0] KIND_HEADER = 3'd0;
  localparam logic [KW-1:0] KIND_ENTRY  = 3'd1;
  localparam logic [KW-1:0] KIND_SEARCH = 3'd2;
  localparam logic [KW-1:0] KIND_EMPTY  = 3'd3;
  localparam logic [KW-1:0] KIND_FULL   = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_HEADER,
    ST_DUMP,
    ST_SCAN
  } state_t;

  typedef struct packed {
    logic          latch;
    logic          write;
    logic          inc;
    logic          dec;
    logic          clr;
    logic          load_ptr;
    logic          step_ptr;
    logic          emit;
    logic [KW-1:0] kind;
    logic          found;
    logic          last;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic empty;
    logic full;
    logic ptr_zero;
    logic hit;
  } sts_t;

endpackage

### sv/lss_dpath.sv
// Datapath of the LIFO stack: entry memory, count, walk pointer, result registers.
// Depends on lss_pkg; driven by lss_ctrl commands.
module lss_dpath #(
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [1:0]               opcode,
  input  logic signed [31:0]       value,
  input  lss_pkg::cmd_t            cmd,
  output lss_pkg::sts_t            sts,
  output logic                     strobe,
  output logic [lss_pkg::KW-1:0]   kind,
  output logic [lss_pkg::CW-1:0]   count,
  output logic signed [31:0]       entry,
  output logic                     found,
  output logic                     last
);
  import lss_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data;
  logic [DW-1:0] value_reg;
  op_t           op_reg;
  logic [CW-1:0] entries;
  logic [CW-1:0] entries_m1;
  logic [AW-1:0] ptr;
  logic [AW-1:0] rd_addr;

  assign entries_m1 = entries - 1'b1;
  assign rd_addr    = cmd.load_ptr ? entries_m1[AW-1:0] : ptr - 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_reg    <= op_t'(opcode);
      value_reg <= value;
    end
    if (cmd.write) begin
      mem[entries[AW-1:0]] <= value_reg;
    end
    rd_data <= mem[rd_addr];
    if (cmd.load_ptr || cmd.step_ptr) begin
      ptr <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entries <= '0;
    end else if (cmd.clr) begin
      entries <= '0;
    end else if (cmd.inc) begin
      entries <= entries + 1'b1;
    end else if (cmd.dec) begin
      entries <= entries_m1;
    end
  end

  // Result registers: fields outside their kind read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit;
    end
    if (cmd.emit) begin
      kind  <= cmd.kind;
      count <= (cmd.kind == KIND_HEADER) ? entries : '0;
      entry <= (cmd.kind == KIND_ENTRY) ? rd_data : '0;
      found <= cmd.found;
      last  <= cmd.last;
    end
  end

  assign sts.op       = op_reg;
  assign sts.empty    = (entries == '0);
  assign sts.full     = (entries == CW'(DEPTH));
  assign sts.ptr_zero = (ptr == '0);
  assign sts.hit      = (rd_data == value_reg);

endmodule

### sv/lss_ctrl.sv
// Controller of the LIFO stack: sequences update, header, dump walk and search walk.
// Depends on lss_pkg; commands lss_dpath.
module lss_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  lss_pkg::sts_t sts,
  output lss_pkg::cmd_t cmd,
  output logic          busy
);
  import lss_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        case (sts.op)
          OP_PUSH:   state_next = sts.full ? ST_IDLE : ST_HEADER;
          OP_POP:    state_next = sts.empty ? ST_IDLE : ST_HEADER;
          OP_CLEAR:  state_next = ST_HEADER;
          OP_SEARCH: state_next = sts.empty ? ST_IDLE : ST_SCAN;
          default:   state_next = ST_IDLE;
        endcase
      end
      ST_HEADER: begin
        state_next = sts.empty ? ST_IDLE : ST_DUMP;
      end
      ST_DUMP: begin
        if (sts.ptr_zero) state_next = ST_IDLE;
      end
      ST_SCAN: begin
        if (sts.hit || sts.ptr_zero) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE: begin
        cmd.latch = start;
      end
      ST_DECIDE: begin
        case (sts.op)
          OP_PUSH: begin
            if (sts.full) begin
              cmd.emit = 1'b1;
              cmd.kind = KIND_FULL;
              cmd.last = 1'b1;
            end else begin
              cmd.write = 1'b1;
              cmd.inc   = 1'b1;
            end
          end
          OP_POP: begin
            if (sts.empty) begin
              cmd.emit = 1'b1;
              cmd.kind = KIND_EMPTY;
              cmd.last = 1'b1;
            end else begin
              cmd.dec = 1'b1;
            end
          end
          OP_CLEAR: begin
            cmd.clr = 1'b1;
          end
          OP_SEARCH: begin
            if (sts.empty) begin
              cmd.emit = 1'b1;
              cmd.kind = KIND_SEARCH;
              cmd.last = 1'b1;
            end else begin
              cmd.load_ptr = 1'b1;
            end
          end
          default: cmd = '0;
        endcase
      end
      ST_HEADER: begin
        // start the top-down read alongside the header
        cmd.emit     = 1'b1;
        cmd.kind     = KIND_HEADER;
        cmd.last     = sts.empty;
        cmd.load_ptr = 1'b1;
      end
      ST_DUMP: begin
        cmd.emit     = 1'b1;
        cmd.kind     = KIND_ENTRY;
        cmd.last     = sts.ptr_zero;
        cmd.step_ptr = 1'b1;
      end
      ST_SCAN: begin
        if (sts.hit || sts.ptr_zero) begin
          cmd.emit  = 1'b1;
          cmd.kind  = KIND_SEARCH;
          cmd.found = sts.hit;
          cmd.last  = 1'b1;
        end else begin
          cmd.step_ptr = 1'b1;
        end
      end
      default: cmd = '0;
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

### sv/lifo_stack_with_search.sv
// LIFO stack with search: push/pop/clear answer with a header then entries top to bottom.
// Push/pop/clear: header after decide and header states, then one entry per cycle; busy
// in decide, header and one dump state per entry after update; next transaction the cycle
// after. Errors and an empty search: one result, busy in decide. Search: busy in decide
// and up to one scan state per entry. The single read port of the entry memory sets the
// pace. Synchronous reset empties the stack; memory is kept and never read unwritten.
`include "lifo_stack_with_search_defines.svh"
module lifo_stack_with_search #(
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               opcode,
  input  logic signed [31:0]       value,
  output logic                     strobe,
  output logic [lss_pkg::KW-1:0]   kind,
  output logic [lss_pkg::CW-1:0]   count,
  output logic signed [31:0]       entry,
  output logic                     found,
  output logic                     last
);
  import lss_pkg::*;

  cmd_t cmd;
  sts_t sts;

  lss_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  lss_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk    (clk),
    .rst    (rst),
    .opcode (opcode),
    .value  (value),
    .cmd    (cmd),
    .sts    (sts),
    .strobe (strobe),
    .kind   (kind),
    .count  (count),
    .entry  (entry),
    .found  (found),
    .last   (last)
  );

  `LSS_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
  `LSS_ASSERT_SAME(a_last_idle, clk, rst, strobe && last, !busy)
  `LSS_ASSERT_NEXT(a_dump_burst, clk, rst, strobe && !last, strobe)
  `LSS_ASSERT_SAME(a_count_bound, clk, rst, strobe && (kind == KIND_HEADER),
                   count <= CW'(DEPTH))

endmodule

### dv/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for lifo_stack_with_search: a directed table, then random phases.
// Every transaction is predicted by a behavioural stack and its results checked in order.
// Depends on lss_pkg and the RTL top level.
module tb;
  import lss_pkg::*;

  localparam int DEPTH = 32;
  localparam int WATCHDOG = 1000;
  localparam int RAND_ITEMS = 185;
  localparam int SHOWN_MAX = 10;

  typedef struct packed {
    logic [KW-1:0] kind;
    logic [CW-1:0] count;
    logic [DW-1:0] entry;
    logic          found;
    logic          last;
  } res_t;

  typedef struct packed {
    op_t           op;
    logic [DW-1:0] v;
    logic          typed;
    res_t          res;
  } row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic [1:0]        opcode = 2'd0;
  logic signed [31:0] value = 32'sd0;
  logic              busy;
  logic              strobe;
  logic [KW-1:0]     kind;
  logic [CW-1:0]     count;
  logic signed [31:0] entry;
  logic              found;
  logic              last;

  // expectation typed into the table, sampled with the transaction
  logic              typed_en = 1'b0;
  res_t              typed_res = '0;

  logic [DW-1:0]     stk [DEPTH];
  int                stk_n = 0;
  res_t              answer_q [$];
  int                errors = 0;
  int                sent = 0;
  logic              no_gaps = 1'b0;

  lifo_stack_with_search #(
    .DEPTH(DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .opcode(opcode),
    .value(value),
    .strobe(strobe),
    .kind(kind),
    .count(count),
    .entry(entry),
    .found(found),
    .last(last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic res_t mk(logic [KW-1:0] k, int c, logic [DW-1:0] e, logic f, logic l);
    res_t r;
    r.kind = k;
    r.count = CW'(c);
    r.entry = e;
    r.found = f;
    r.last = l;
    return r;
  endfunction

  task automatic dump_expect();
    int i;
    answer_q.push_back(mk(KIND_HEADER, stk_n, '0, 1'b0, stk_n == 0));
    for (i = stk_n - 1; i >= 0; i--) begin
      answer_q.push_back(mk(KIND_ENTRY, 0, stk[i], 1'b0, i == 0));
    end
  endtask

  task automatic stack_apply(op_t op, logic [DW-1:0] v);
    int i;
    logic hit;
    hit = 1'b0;
    case (op)
      OP_PUSH: begin
        if (stk_n >= DEPTH) begin
          answer_q.push_back(mk(KIND_FULL, 0, '0, 1'b0, 1'b1));
        end else begin
          stk[stk_n] = v;
          stk_n++;
          dump_expect();
        end
      end
      OP_POP: begin
        if (stk_n == 0) begin
          answer_q.push_back(mk(KIND_EMPTY, 0, '0, 1'b0, 1'b1));
        end else begin
          stk_n--;
          dump_expect();
        end
      end
      OP_CLEAR: begin
        stk_n = 0;
        dump_expect();
      end
      default: begin
        for (i = stk_n - 1; i >= 0; i--) begin
          if (stk[i] == v) hit = 1'b1;
        end
        answer_q.push_back(mk(KIND_SEARCH, 0, '0, hit, 1'b1));
      end
    endcase
  endtask

  // predict on every accepted transaction
  always @(posedge clk) begin
    int n0;
    if (!rst && start && busy === 1'b0) begin
      n0 = answer_q.size();
      stack_apply(op_t'(opcode), value);
      if (typed_en) begin
        while (answer_q.size() > n0) void'(answer_q.pop_back());
        answer_q.push_back(typed_res);
      end
    end
  end

  task automatic report(string what, res_t want, res_t got);
    errors++;
    if (errors <= SHOWN_MAX) begin
      $display("%0t %s: expected kind=%0d count=%0d entry=%h found=%b last=%b",
               $realtime, what, want.kind, want.count, want.entry, want.found, want.last);
      $display("%0t %s:   actual kind=%0d count=%0d entry=%h found=%b last=%b",
               $realtime, what, got.kind, got.count, got.entry, got.found, got.last);
    end
  endtask

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (!rst && strobe === 1'b1) begin
      got = mk(kind, int'(count), entry, found, last);
      if (answer_q.size() == 0) begin
        report("unexpected result", '0, got);
      end else begin
        want = answer_q.pop_front();
        if (got.kind !== want.kind || got.count !== want.count || got.entry !== want.entry ||
            got.found !== want.found || got.last !== want.last) begin
          report("result mismatch", want, got);
        end
      end
    end
  end

  // end the run if nothing moves for too long
  initial begin
    int stuck;
    stuck = 0;
    while (stuck < WATCHDOG) begin
      @(posedge clk);
      if (rst || (start && busy === 1'b0) || strobe === 1'b1) stuck = 0;
      else stuck++;
    end
    $display("FAIL");
    $finish;
  end

  task automatic issue(op_t op, logic [DW-1:0] v, logic t, res_t r);
    start <= 1'b1;
    opcode <= op;
    value <= v;
    typed_en <= t;
    typed_res <= r;
    do @(posedge clk); while (busy !== 1'b0);
    sent++;
  endtask

  task automatic maybe_idle();
    if (!no_gaps && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  // hold off until every outstanding result has come back
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (answer_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [DW-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0000_0000;
      3, 4, 5: return DW'($urandom_range(0, 15));
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [DW-1:0] search_value();
    logic [DW-1:0] v;
    int r;
    int b;
    r = $urandom_range(0, 3);
    if (stk_n > 0 && r < 2) begin
      v = stk[$urandom_range(0, stk_n - 1)];
      if (r == 1) begin
        // near miss: one bit away from a held entry
        b = $urandom_range(0, DW - 1);
        v[b] = ~v[b];
      end
      return v;
    end
    return pick_value();
  endfunction

  task automatic mixed_phase(int n);
    int r;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 40) issue(OP_PUSH, pick_value(), 1'b0, '0);
      else if (r < 65) issue(OP_POP, pick_value(), 1'b0, '0);
      else if (r < 95) issue(OP_SEARCH, search_value(), 1'b0, '0);
      else issue(OP_CLEAR, pick_value(), 1'b0, '0);
      maybe_idle();
    end
  endtask

  task automatic fill_phase();
    int n;
    settle();
    n = DEPTH - stk_n + 1 + $urandom_range(0, 2);
    repeat (n) begin
      if ($urandom_range(0, 7) == 0) issue(OP_SEARCH, search_value(), 1'b0, '0);
      issue(OP_PUSH, pick_value(), 1'b0, '0);
      maybe_idle();
    end
  endtask

  task automatic drain_phase();
    int n;
    settle();
    n = stk_n + 1 + $urandom_range(0, 1);
    repeat (n) begin
      issue(OP_POP, pick_value(), 1'b0, '0);
      maybe_idle();
    end
  endtask

  initial begin
    row_t plan [22];
    int sel;
    plan = '{
      '{OP_CLEAR,  32'h0000_0000, 1'b1, mk(KIND_HEADER, 0, '0, 1'b0, 1'b1)},
      '{OP_POP,    32'h0000_0000, 1'b1, mk(KIND_EMPTY, 0, '0, 1'b0, 1'b1)},
      '{OP_SEARCH, 32'h0000_0000, 1'b1, mk(KIND_SEARCH, 0, '0, 1'b0, 1'b1)},
      '{OP_PUSH,   32'h7fff_ffff, 1'b0, '0},
      '{OP_PUSH,   32'h8000_0000, 1'b0, '0},
      '{OP_PUSH,   32'h0000_0000, 1'b0, '0},
      '{OP_PUSH,   32'hffff_ffff, 1'b0, '0},
      '{OP_SEARCH, 32'h8000_0000, 1'b0, '0},
      '{OP_SEARCH, 32'h8000_0001, 1'b0, '0},
      '{OP_SEARCH, 32'h7fff_fffe, 1'b0, '0},
      '{OP_SEARCH, 32'hffff_ffff, 1'b0, '0},
      '{OP_POP,    32'hffff_ffff, 1'b0, '0},
      '{OP_SEARCH, 32'hffff_ffff, 1'b0, '0},
      '{OP_PUSH,   32'h5555_5555, 1'b0, '0},
      '{OP_PUSH,   32'haaaa_aaaa, 1'b0, '0},
      '{OP_POP,    32'h0000_0000, 1'b0, '0},
      '{OP_CLEAR,  32'hffff_ffff, 1'b0, '0},
      // stale memory must not match once the stack is empty
      '{OP_SEARCH, 32'h7fff_ffff, 1'b1, mk(KIND_SEARCH, 0, '0, 1'b0, 1'b1)},
      '{OP_POP,    32'h7fff_ffff, 1'b1, mk(KIND_EMPTY, 0, '0, 1'b0, 1'b1)},
      '{OP_CLEAR,  32'h8000_0000, 1'b1, mk(KIND_HEADER, 0, '0, 1'b0, 1'b1)},
      '{OP_PUSH,   32'h0000_0001, 1'b0, '0},
      '{OP_SEARCH, 32'h0000_0001, 1'b0, '0}
    };
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      issue(plan[i].op, plan[i].v, plan[i].typed, plan[i].res);
      maybe_idle();
    end
    settle();

    fill_phase();
    mixed_phase(10);
    drain_phase();
    while (sent < RAND_ITEMS) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      sel = $urandom_range(0, 5);
      if (sel == 0) fill_phase();
      else if (sel == 1) drain_phase();
      else mixed_phase($urandom_range(8, 20));
      if ($urandom_range(0, 2) == 0) settle();
    end

    // closing stretch without gaps
    no_gaps = 1'b1;
    mixed_phase(25);
    start <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### lifo_stack_with_search.f
+incdir+sv
sv/lss_pkg.sv
sv/lss_dpath.sv
sv/lss_ctrl.sv
sv/lifo_stack_with_search.sv
dv/tb.sv
